FILE: src/nrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrc_pkg
// Widths, reset values, register codes and pipeline payload types of the
// Neuber / Ramberg-Osgood correction unit.
// ----------------------------------------------------------------------------
package nrc_pkg;

	localparam int WSTR = 40;            // stress, Q24.16
	localparam int WSTN = 32;            // strain, Q2.30
	localparam int WHC  = 24;            // hardening coefficient, Q8.16
	localparam int WDIG = 8;             // multiplier digit

	localparam int NEDIG = WSTN / WDIG;  // strain digits
	localparam int NSDIG = WSTR / WDIG;  // stress digits
	localparam int NYDIG = WSTR / WDIG;  // register digits in the sequencer
	localparam int SEQ_LAST = 2 * NYDIG - 1;
	localparam int WSEQ = 4;

	localparam int WY2  = 2 * WSTR;            // Y^2
	localparam int WD   = 3 * WSTR;            // E*Y^2
	localparam int WP   = WD + WSTN;           // E*Y^2*|strain|
	localparam int WR   = WP + WSTR;           // E*W*Y^2
	localparam int RSH  = 14;
	localparam int WRS  = WR - RSH;
	localparam int WA1  = WHC + WSTR;          // a*m
	localparam int WA2  = WHC + 2 * WSTR;      // a*m^2
	localparam int WA3  = WHC + 3 * WSTR;      // a*m^3
	localparam int WA4  = WHC + 4 * WSTR;      // a*m^4
	localparam int WKM  = WY2 + WSTR;          // Y^2*m
	localparam int WKM2 = WY2 + 2 * WSTR;      // Y^2*m^2
	localparam int WG   = WA4 + 2;
	localparam int WNUM = 160;

	localparam int NROOT = WSTR;
	localparam int NDIV  = WSTN;

	localparam int ST_ROOT0 = 2 + NEDIG + NSDIG;
	localparam int ST_CLIP  = ST_ROOT0 + NROOT;
	localparam int ST_DIV0  = ST_CLIP + 1;
	localparam int NST      = ST_DIV0 + NDIV;

	localparam logic [WSTR-1:0] YOUNG_RST = 40'd13762560000;
	localparam logic [WSTR-1:0] YIELD_RST = 40'd16384000;
	localparam logic [WHC-1:0]  HARD_RST  = 24'd65536;

	localparam logic [WSTR-1:0] STRESS_MAX = {1'b0, {(WSTR-1){1'b1}}};
	localparam logic [WSTN-1:0] STRAIN_MAX = {1'b0, {(WSTN-1){1'b1}}};

	typedef enum logic [1:0] {
		CFG_YOUNG = 2'd0,
		CFG_YIELD = 2'd1,
		CFG_HARD  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [WP-1:0]   p;
		logic [WR-1:0]   r;
		logic [WSTR-1:0] smag;
		logic [WSTN-1:0] emag;
		logic            sneg;
		logic            eneg;
	} mul_t;

	typedef struct packed {
		logic [WSTR-1:0] m;
		logic [WKM-1:0]  km;
		logic [WKM2-1:0] km2;
		logic [WA1-1:0]  a1;
		logic [WA2-1:0]  a2;
		logic [WA3-1:0]  a3;
		logic [WA4-1:0]  a4;
		logic [WRS-1:0]  rs;
		logic            sneg;
		logic            eneg;
	} root_t;

	typedef struct packed {
		logic [WSTN-1:0] q;
		logic [WNUM-1:0] rem;
		logic [WSTR-1:0] m;
		logic            sneg;
		logic            eneg;
		logic            sat;
	} div_t;

endpackage
`default_nettype wire

FILE: src/neuber_ramberg_osgood_correction_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// neuber_ramberg_osgood_correction_unit
// Neuber correction with Ramberg-Osgood hardening (exponent 3) for one
// stress / strain component, fully pipelined in fixed point.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   item     | item_valid / item_stall    | stress_in, strain_in
//   result   | result_valid / result_stall| stress_out, strain_out, saturated
//   config   | cfg_wr_en                  | cfg_index, cfg_data
//
// one request per cycle while item_stall is low
// the pipeline holds the 9 digit multiply stages, 40 stress root bits, 32 quotient bits
// after reset and after each config write, the E*Y^2 precompute stalls
// the item side; a stalled result only holds stages that have no bubble ahead
// ----------------------------------------------------------------------------
module neuber_ramberg_osgood_correction_unit
	import nrc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic signed [WSTR-1:0] stress_in,
	input  logic signed [WSTN-1:0] strain_in,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic signed [WSTR-1:0] stress_out,
	output logic signed [WSTN-1:0] strain_out,
	output logic                   saturated,
	input  logic                   cfg_wr_en,
	input  logic [1:0]             cfg_index,
	input  logic [WSTR-1:0]        cfg_data
);

	logic [WSTR-1:0] young_q, yield_q;
	logic [WHC-1:0]  hard_q;
	logic [WY2-1:0]  y2_q;
	logic [WD-1:0]   d_q;
	logic            busy_q;
	logic [WSEQ-1:0] seq_q;
	logic [2:0]      dig;
	logic [5:0]      sh;
	logic [WDIG-1:0] ybyte, ebyte;
	logic [WSTR+WDIG-1:0] ypp;
	logic [WY2+WDIG-1:0]  dpp;

	logic [NST:1] v_q;
	logic [NST:1] stage_en;
	logic         out_free;
	logic         item_take;

	mul_t  mul_s [0:NSDIG+NEDIG];
	mul_t  abs_d;
	root_t root_p [0:NROOT];
	div_t  clip_s51;
	div_t  clip_d;
	div_t  div_p [0:NDIV];

	logic [WSTR-1:0] stress_q;
	logic [WSTN-1:0] strain_q;
	logic            sat_q;

	// config registers and E*Y^2 precompute
	always_comb begin
		dig   = (seq_q < WSEQ'(NYDIG)) ? seq_q[2:0] : 3'(seq_q - WSEQ'(NYDIG));
		sh    = {dig, 3'b000};
		ybyte = yield_q[sh +: WDIG];
		ebyte = young_q[sh +: WDIG];
		ypp   = yield_q * ybyte;
		dpp   = y2_q * ebyte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			young_q <= YOUNG_RST;
			yield_q <= YIELD_RST;
			hard_q  <= HARD_RST;
			busy_q  <= 1'b1;
			seq_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_YOUNG: young_q <= cfg_data;
				CFG_YIELD: yield_q <= cfg_data;
				CFG_HARD:  hard_q  <= cfg_data[WHC-1:0];
				default: ;
			endcase
			busy_q <= 1'b1;
			seq_q  <= '0;
		end else if (busy_q) begin
			seq_q <= seq_q + 1'b1;
			if (seq_q == WSEQ'(SEQ_LAST)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !cfg_wr_en) begin
			if (seq_q < WSEQ'(NYDIG)) begin
				y2_q <= ((seq_q == '0) ? '0 : y2_q) + (WY2'(ypp) << sh);
			end else begin
				d_q <= ((seq_q == WSEQ'(NYDIG)) ? '0 : d_q) + (WD'(dpp) << sh);
			end
		end
	end

	// flow control: a stage moves when the result is not stalled or any stage at or after it is empty
	assign out_free  = !(v_q[NST] && result_stall);
	assign item_stall = !stage_en[1] || busy_q || cfg_wr_en;
	assign item_take = item_valid && !item_stall;

	for (genvar k = 1; k <= NST; k++) begin : g_en
		assign stage_en[k] = out_free || !(&v_q[NST:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (stage_en[1]) begin
				v_q[1] <= item_take;
			end
			for (int k = 2; k <= NST; k++) begin
				if (stage_en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// magnitudes and signs
	always_comb begin
		abs_d      = '0;
		abs_d.sneg = stress_in[WSTR-1];
		abs_d.eneg = strain_in[WSTN-1];
		abs_d.smag = stress_in[WSTR-1] ? (~stress_in + 1'b1) : stress_in;
		abs_d.emag = strain_in[WSTN-1] ? (~strain_in + 1'b1) : strain_in;
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			mul_s[0] <= abs_d;
		end
	end

	// E*Y^2 times |strain|, one byte a stage
	for (genvar j = 0; j < NEDIG; j++) begin : g_emul
		mul_t                nxt;
		logic [WD+WDIG-1:0]  pp;
		always_comb begin
			pp    = d_q * mul_s[j].emag[j*WDIG +: WDIG];
			nxt   = mul_s[j];
			nxt.p = mul_s[j].p + (WP'(pp) << (j * WDIG));
		end
		always_ff @(posedge clk) begin
			if (stage_en[j+2]) begin
				mul_s[j+1] <= nxt;
			end
		end
	end

	// times |stress|, one byte a stage
	for (genvar j = 0; j < NSDIG; j++) begin : g_smul
		mul_t                nxt;
		logic [WP+WDIG-1:0]  pp;
		always_comb begin
			pp    = mul_s[NEDIG+j].p * mul_s[NEDIG+j].smag[j*WDIG +: WDIG];
			nxt   = mul_s[NEDIG+j];
			nxt.r = mul_s[NEDIG+j].r + (WR'(pp) << (j * WDIG));
		end
		always_ff @(posedge clk) begin
			if (stage_en[NEDIG+j+2]) begin
				mul_s[NEDIG+j+1] <= nxt;
			end
		end
	end

	// stress magnitude search, msb first
	always_comb begin
		root_p[0]      = '0;
		root_p[0].rs   = mul_s[NSDIG+NEDIG].r[WR-1:RSH];
		root_p[0].sneg = mul_s[NSDIG+NEDIG].sneg;
		root_p[0].eneg = mul_s[NSDIG+NEDIG].eneg;
	end

	for (genvar i = 0; i < NROOT; i++) begin : g_root
		nrc_root_stage #(
			.BIT(NROOT - 1 - i)
		) u_root (
			.clk (clk),
			.en  (stage_en[ST_ROOT0+i]),
			.hc  (hard_q),
			.y2  (y2_q),
			.d   (root_p[i]),
			.q   (root_p[i+1])
		);
	end

	// stress clip and strain numerator
	always_comb begin
		logic [WSTR-1:0] m;
		logic [WKM-1:0]  km;
		logic [WA3-1:0]  a3, t, s;
		m  = root_p[NROOT].m;
		km = root_p[NROOT].km;
		a3 = root_p[NROOT].a3;
		t  = WA3'(hard_q) << 78;
		s  = WA3'(hard_q) << 39;
		clip_d      = '0;
		clip_d.sneg = root_p[NROOT].sneg;
		clip_d.eneg = root_p[NROOT].eneg;
		if (m[WSTR-1]) begin
			m  = STRESS_MAX;
			km = (WKM'(y2_q) << (WSTR - 1)) - WKM'(y2_q);
			a3 = (WA3'(hard_q) << 117) - t - (t << 1) + s + (s << 1) - WA3'(hard_q);
			clip_d.sat = 1'b1;
		end
		clip_d.m   = m;
		clip_d.rem = (WNUM'(km) << (16 + RSH)) + (WNUM'(a3) << RSH);
	end

	always_ff @(posedge clk) begin
		if (stage_en[ST_CLIP]) begin
			clip_s51 <= clip_d;
		end
	end

	// strain quotient, msb first
	assign div_p[0] = clip_s51;

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		nrc_div_stage #(
			.BIT(NDIV - 1 - i)
		) u_div (
			.clk (clk),
			.en  (stage_en[ST_DIV0+i]),
			.den (d_q),
			.d   (div_p[i]),
			.q   (div_p[i+1])
		);
	end

	// strain clip, signs, result register
	always_ff @(posedge clk) begin
		if (stage_en[NST]) begin
			stress_q <= div_p[NDIV].sneg ? (~div_p[NDIV].m + 1'b1) : div_p[NDIV].m;
			if (div_p[NDIV].q[WSTN-1]) begin
				strain_q <= div_p[NDIV].eneg ? (~STRAIN_MAX + 1'b1) : STRAIN_MAX;
				sat_q    <= 1'b1;
			end else begin
				strain_q <= div_p[NDIV].eneg ? (~div_p[NDIV].q + 1'b1) : div_p[NDIV].q;
				sat_q    <= div_p[NDIV].sat;
			end
		end
	end

	assign result_valid = v_q[NST];
	assign stress_out   = stress_q;
	assign strain_out   = strain_q;
	assign saturated    = sat_q;

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> busy_q)
		else $error("precompute not restarted after config write");

	a_first_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_q[1]) |-> $past(item_valid && !item_stall))
		else $error("first stage filled without a request");

	a_clip_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[ST_CLIP] && !stage_en[ST_CLIP] |=> v_q[ST_CLIP])
		else $error("held stage lost its request");

endmodule
`default_nettype wire

FILE: src/nrc_root_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrc_root_stage
// One bit of the stress magnitude search. Powers of the trial value are kept
// as running sums, so a trial bit costs only shifted adds and one compare.
// ----------------------------------------------------------------------------
module nrc_root_stage
	import nrc_pkg::*;
#(
	parameter int BIT = 0
) (
	input  logic           clk,
	input  logic           en,
	input  logic [WHC-1:0] hc,
	input  logic [WY2-1:0] y2,
	input  root_t          d,
	output root_t          q
);

	logic [WA1-1:0]  c1;
	logic [WA2-1:0]  c2;
	logic [WA3-1:0]  c3, t3, u3;
	logic [WA4-1:0]  c4, v2;
	logic [WKM-1:0]  ck1;
	logic [WKM2-1:0] ck2;
	logic [WG-1:0]   g;
	logic            take;
	root_t           nxt;

	always_comb begin
		c1  = d.a1 + (WA1'(hc) << BIT);
		c2  = d.a2 + (WA2'(d.a1) << (BIT + 1)) + (WA2'(hc) << (2 * BIT));
		t3  = WA3'(d.a2) << BIT;
		u3  = WA3'(d.a1) << (2 * BIT);
		c3  = d.a3 + t3 + (t3 << 1) + u3 + (u3 << 1) + (WA3'(hc) << (3 * BIT));
		v2  = WA4'(d.a2) << (2 * BIT);
		c4  = d.a4 + (WA4'(d.a3) << (BIT + 2)) + (v2 << 1) + (v2 << 2)
			+ (WA4'(d.a1) << (3 * BIT + 2)) + (WA4'(hc) << (4 * BIT));
		ck1 = d.km + (WKM'(y2) << BIT);
		ck2 = d.km2 + (WKM2'(d.km) << (BIT + 1)) + (WKM2'(y2) << (2 * BIT));
		g   = (WG'(ck2) << 16) + WG'(c4);
		take = (g <= WG'(d.rs));

		nxt = d;
		if (take) begin
			nxt.m   = d.m | (WSTR'(1) << BIT);
			nxt.a1  = c1;
			nxt.a2  = c2;
			nxt.a3  = c3;
			nxt.a4  = c4;
			nxt.km  = ck1;
			nxt.km2 = ck2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule
`default_nettype wire

FILE: src/nrc_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrc_div_stage
// One restoring step of the strain quotient num / (E*Y^2).
// ----------------------------------------------------------------------------
module nrc_div_stage
	import nrc_pkg::*;
#(
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [WD-1:0] den,
	input  div_t          d,
	output div_t          q
);

	logic [WNUM-1:0] ds;
	div_t            nxt;

	always_comb begin
		ds  = WNUM'(den) << BIT;
		nxt = d;
		if (d.rem >= ds) begin
			nxt.rem = d.rem - ds;
			nxt.q   = d.q | (WSTN'(1) << BIT);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Neuber / Ramberg-Osgood correction unit.
// Requests go in under random sender idling and receiver stalls. Each accepted
// request is predicted with exact wide integer arithmetic, which bisects the
// stress root and the strain quotient. The prediction is queued and compared
// with the results in order. Runs cover several register settings.
// ----------------------------------------------------------------------------
module tb;
	import nrc_pkg::*;

	typedef bit [255:0] wide_t;

	typedef struct {
		logic [WSTR-1:0] stress;
		logic [WSTN-1:0] strain;
		logic            sat;
	} correction_t;

	class correction_board;
		logic [WSTR-1:0] young;
		logic [WSTR-1:0] yield_s;
		logic [WHC-1:0]  hard;
		correction_t     pending[$];

		function new();
			young = YOUNG_RST;
			yield_s = YIELD_RST;
			hard = HARD_RST;
		endfunction

		function void note_request(logic [WSTR-1:0] s, logic [WSTN-1:0] e);
			wide_t smag, emag, y2, y2s, rhs, den, m, q, c, num, hv;
			correction_t r;
			smag = s[WSTR-1] ? wide_t'((~s) + 1'b1) & wide_t'({WSTR{1'b1}}) : wide_t'(s);
			emag = e[WSTN-1] ? wide_t'((~e) + 1'b1) & wide_t'({WSTN{1'b1}}) : wide_t'(e);
			y2 = wide_t'(yield_s) * wide_t'(yield_s);
			y2s = y2 << 16;
			rhs = wide_t'(young) * (smag * emag) * y2;
			den = wide_t'(young) * y2;
			m = 0;
			for (int b = WSTR - 1; b >= 0; b--) begin
				c = m | (wide_t'(1) << b);
				hv = y2s + wide_t'(hard) * (c * c);
				if (((c * c * hv) << 14) <= rhs)
					m = c;
			end
			r.sat = 1'b0;
			if (m > wide_t'(STRESS_MAX)) begin
				m = wide_t'(STRESS_MAX);
				r.sat = 1'b1;
			end
			num = (m * (y2s + wide_t'(hard) * (m * m))) << 14;
			q = 0;
			for (int b = WSTN - 1; b >= 0; b--) begin
				c = q | (wide_t'(1) << b);
				if (c * den <= num)
					q = c;
			end
			if (q > wide_t'(STRAIN_MAX)) begin
				q = wide_t'(STRAIN_MAX);
				r.sat = 1'b1;
			end
			r.stress = s[WSTR-1] ? -m[WSTR-1:0] : m[WSTR-1:0];
			r.strain = e[WSTN-1] ? -q[WSTN-1:0] : q[WSTN-1:0];
			pending.push_back(r);
		endfunction

		function string check_result(logic [WSTR-1:0] s, logic [WSTN-1:0] e, logic sat);
			correction_t x;
			if (pending.size() == 0)
				return "result with no request outstanding";
			x = pending.pop_front();
			if (s !== x.stress || e !== x.strain || sat !== x.sat)
				return $sformatf("got stress %h strain %h sat %b, want %h %h %b",
					s, e, sat, x.stress, x.strain, x.sat);
			return "";
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	logic signed [WSTR-1:0] stress_in = '0;
	logic signed [WSTN-1:0] strain_in = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic signed [WSTR-1:0] stress_out;
	logic signed [WSTN-1:0] strain_out;
	logic                   saturated;
	logic                   cfg_wr_en = 1'b0;
	logic [1:0]             cfg_index = '0;
	logic [WSTR-1:0]        cfg_data = '0;

	correction_board board = new();
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	neuber_ramberg_osgood_correction_unit u_top (.*);

	always #2 clk = ~clk;

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		string msg;
		result_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && result_valid && !result_stall) begin
			msg = board.check_result(stress_out, strain_out, saturated);
			if (msg != "")
				report(msg);
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [WSTR-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_YOUNG: board.young = val;
			CFG_YIELD: board.yield_s = val;
			default: board.hard = val[WHC-1:0];
		endcase
		@(posedge clk);
	endtask

	task automatic send(logic [WSTR-1:0] s, logic [WSTN-1:0] e);
		if ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		item_valid <= 1'b1;
		stress_in <= s;
		strain_in <= e;
		do @(posedge clk); while (item_stall);
		board.note_request(s, e);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [WSTR-1:0] rand_stress();
		logic [63:0] v;
		v = {$urandom, $urandom};
		if ($urandom_range(3) != 0)
			v = $signed(v) >>> $urandom_range(39, 10);
		return v[WSTR-1:0];
	endfunction

	function automatic logic [WSTN-1:0] rand_strain();
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(3) != 0)
			v = $signed(v) >>> $urandom_range(22, 3);
		return v;
	endfunction

	localparam logic [WSTR-1:0] SMAX = STRESS_MAX;
	localparam logic [WSTR-1:0] SMIN = {1'b1, {(WSTR-1){1'b0}}};
	localparam logic [WSTN-1:0] EMAX = STRAIN_MAX;
	localparam logic [WSTN-1:0] EMIN = {1'b1, {(WSTN-1){1'b0}}};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 8; ph++) begin
			idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 16 : 72) : 0;
			stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 16 : 72) : 0;
			if (ph == 1) begin
				write_reg(CFG_YOUNG, SMAX);
				write_reg(CFG_YIELD, SMAX);
				write_reg(CFG_HARD, 40'hFFFFFF);
			end else if (ph == 2) begin
				write_reg(CFG_YOUNG, 40'd1);
				write_reg(CFG_YIELD, 40'd1);
				write_reg(CFG_HARD, 40'd1);
			end else if (ph == 3) begin
				write_reg(CFG_YOUNG, 40'hFF_FFFF_FFFF);
				write_reg(CFG_YIELD, 40'd1);
				write_reg(CFG_HARD, 40'd65536);
			end else if (ph > 3) begin
				write_reg(CFG_YOUNG, 40'({$urandom_range(255), $urandom} | 64'd1));
				write_reg(CFG_YIELD,
					40'({$urandom_range(255), $urandom} >> $urandom_range(16) | 64'd1));
				write_reg(CFG_HARD, 40'($urandom_range(24'hFFFFFF, 1)));
			end
			send('0, '0);
			send(SMAX, EMAX);
			send(SMIN, EMIN);
			send(SMIN, EMAX);
			send(SMAX, EMIN);
			send('1, '1);
			send(40'd1, 32'd1);
			send('0, EMAX);
			send(SMAX, '0);
			send(40'd500 << 16, 32'd2684354);
			send(-(40'd500 << 16), 32'd2684354);
			send(40'd500 << 16, -32'd2684354);
			send(40'd100 << 16, 32'd100000);
			for (int i = 0; i < 95; i++)
				send(rand_stress(), rand_strain());
			drain();
		end
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
